[rtl/tes_pkg.sv]
package tes_pkg;

  localparam int MAX_SAMPLE_DEF = 8192;
  localparam int SAMPLE_LEN_W = 14;
  localparam int PCT_W = 7;
  localparam logic [PCT_W-1:0] PCT_RESET = 7'd90;

  localparam logic [7:0] BOM_EF = 8'hEF;
  localparam logic [7:0] BOM_BB = 8'hBB;
  localparam logic [7:0] BOM_BF = 8'hBF;
  localparam logic [7:0] BOM_FF = 8'hFF;
  localparam logic [7:0] BOM_FE = 8'hFE;
  localparam logic [7:0] U8_MASK_C0 = 8'hC0;
  localparam logic [7:0] U8_MASK_E0 = 8'hE0;
  localparam logic [7:0] U8_MASK_F0 = 8'hF0;
  localparam logic [7:0] U8_MASK_F8 = 8'hF8;
  localparam logic [7:0] U8_CONT = 8'h80;
  localparam logic [7:0] U8_LEAD2 = 8'hC0;
  localparam logic [7:0] U8_LEAD3 = 8'hE0;
  localparam logic [7:0] U8_LEAD4 = 8'hF0;
  localparam logic [15:0] SURR_HI_MIN = 16'hD800;
  localparam logic [15:0] SURR_HI_MAX = 16'hDBFF;
  localparam logic [15:0] SURR_LO_MIN = 16'hDC00;
  localparam logic [15:0] SURR_LO_MAX = 16'hDFFF;
  localparam logic [6:0] PCT_SCALE = 7'd100;

  typedef enum logic [2:0] {
    TT_PLAIN    = 3'd0,
    TT_ASCII    = 3'd1,
    TT_UTF8     = 3'd2,
    TT_UTF8_BOM = 3'd3,
    TT_UTF16LE  = 3'd4,
    TT_UTF16BE  = 3'd5,
    TT_UTF32LE  = 3'd6,
    TT_UTF32BE  = 3'd7
  } enc_kind_t;

  typedef struct packed {
    logic expect_low;
    logic fail;
  } u16_lane_t;

  function automatic logic is_printable(logic [7:0] b);
    return (b >= 8'd32 && b <= 8'd126) || b == 8'd9 || b == 8'd10 || b == 8'd13;
  endfunction

  function automatic u16_lane_t utf16_unit(logic [15:0] unit, u16_lane_t cur);
    u16_lane_t r;
    logic hi;
    logic lo;
    hi = unit >= SURR_HI_MIN && unit <= SURR_HI_MAX;
    lo = unit >= SURR_LO_MIN && unit <= SURR_LO_MAX;
    r = cur;
    if (cur.expect_low) begin
      if (!lo) r.fail = 1'b1;
      r.expect_low = 1'b0;
    end else if (hi) begin
      r.expect_low = 1'b1;
    end else if (lo) begin
      r.fail = 1'b1;
    end
    return r;
  endfunction

endpackage

[rtl/tes_in_if.sv]
interface tes_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output data_byte, output last, input ready);
  modport sink (input valid, input data_byte, input last, output ready);
endinterface

[rtl/tes_out_if.sv]
interface tes_out_if;
  logic                            valid;
  logic                            ready;
  logic [2:0]                      enc_kind;
  logic [tes_pkg::SAMPLE_LEN_W-1:0] sample_length;

  modport source (output valid, output enc_kind, output sample_length, input ready);
  modport sink (input valid, input enc_kind, input sample_length, output ready);
endinterface

[rtl/text_encoding_sniffer_unit.sv]
// Path: a byte passes through the input register, then the result register.
// Throughput: one byte per cycle unless a last byte stalls; only the byte flagged last yields a result request.
// The next sample streams in while a result waits; only a last byte stalls behind it.
// Reset (rst_n low, synchronous): sample state cleared, printable_percent back to 90,
// both registers empty.
module text_encoding_sniffer_unit #(
  parameter int MAX_SAMPLE = tes_pkg::MAX_SAMPLE_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  tes_in_if.sink                     in_chan,
  tes_out_if.source                  out_chan,
  input  logic                       cfg_we,
  input  logic [tes_pkg::PCT_W-1:0]  cfg_data
);

  localparam int CW = $clog2(MAX_SAMPLE + 1);
  localparam int PW = CW + tes_pkg::PCT_W;

  // input register
  logic       in_v_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;

  // sample state
  logic [tes_pkg::PCT_W-1:0] pct_r;
  logic [31:0]               head_r, head_nxt;
  logic [CW-1:0]             cnt_r, cnt_nxt;
  logic [CW-1:0]             prn_r, prn_nxt;
  logic                      zero_r, zero_nxt;
  logic [1:0]                u8_pend_r, u8_pend_nxt;
  logic                      u8_bad_r, u8_bad_nxt;
  logic                      u8_fail_r, u8_fail_nxt;
  logic [7:0]                prev_r, prev_nxt;
  tes_pkg::u16_lane_t        le_r, le_nxt, be_r, be_nxt;

  // result register
  logic                       out_v_r;
  tes_pkg::enc_kind_t         tt_r, tt_nxt;
  logic [CW-1:0]              len_r;

  logic process;
  logic take;
  logic [PW-1:0] prn_scaled, cnt_scaled;
  logic [CW+tes_pkg::SAMPLE_LEN_W-1:0] len_ext;

  assign process = in_v_r && (!in_last_r || !out_v_r || out_chan.ready);
  assign in_chan.ready = !in_v_r || process;
  assign take = cnt_r < CW'(MAX_SAMPLE);

  always_comb begin
    head_nxt    = head_r;
    cnt_nxt     = cnt_r;
    prn_nxt     = prn_r;
    zero_nxt    = zero_r;
    u8_pend_nxt = u8_pend_r;
    u8_bad_nxt  = u8_bad_r;
    u8_fail_nxt = u8_fail_r;
    prev_nxt    = prev_r;
    le_nxt      = le_r;
    be_nxt      = be_r;
    if (take) begin
      if (cnt_r < CW'(4)) head_nxt[{cnt_r[1:0], 3'b000} +: 8] = in_byte_r;
      if (tes_pkg::is_printable(in_byte_r)) prn_nxt = prn_r + CW'(1);
      else if (in_byte_r == 8'd0) zero_nxt = 1'b1;

      if (u8_pend_r != 2'd0) begin
        if ((in_byte_r & tes_pkg::U8_MASK_C0) != tes_pkg::U8_CONT) u8_bad_nxt = 1'b1;
        u8_pend_nxt = u8_pend_r - 2'd1;
        if (u8_pend_nxt == 2'd0) begin
          if (u8_bad_nxt) u8_fail_nxt = 1'b1;
          u8_bad_nxt = 1'b0;
        end
      end else if (!in_byte_r[7]) begin
        u8_pend_nxt = 2'd0;
      end else if ((in_byte_r & tes_pkg::U8_MASK_E0) == tes_pkg::U8_LEAD2) begin
        u8_pend_nxt = 2'd1;
      end else if ((in_byte_r & tes_pkg::U8_MASK_F0) == tes_pkg::U8_LEAD3) begin
        u8_pend_nxt = 2'd2;
      end else if ((in_byte_r & tes_pkg::U8_MASK_F8) == tes_pkg::U8_LEAD4) begin
        u8_pend_nxt = 2'd3;
      end else begin
        u8_fail_nxt = 1'b1;
      end

      // odd index closes a 16-bit code unit
      if (cnt_r[0]) begin
        le_nxt = tes_pkg::utf16_unit({in_byte_r, prev_r}, le_r);
        be_nxt = tes_pkg::utf16_unit({prev_r, in_byte_r}, be_r);
      end
      prev_nxt = in_byte_r;
      cnt_nxt  = cnt_r + CW'(1);
    end
  end

  assign prn_scaled = PW'(prn_nxt) * PW'(tes_pkg::PCT_SCALE);
  assign cnt_scaled = PW'(pct_r) * PW'(cnt_nxt);

  always_comb begin
    logic bom3, bom4;
    logic [1:0] bad16;
    bom3  = cnt_nxt >= CW'(3);
    bom4  = cnt_nxt >= CW'(4);
    bad16 = {be_nxt.fail | be_nxt.expect_low, le_nxt.fail | le_nxt.expect_low};
    if (bom3 && head_nxt[7:0] == tes_pkg::BOM_EF && head_nxt[15:8] == tes_pkg::BOM_BB
        && head_nxt[23:16] == tes_pkg::BOM_BF) begin
      tt_nxt = tes_pkg::TT_UTF8_BOM;
    end else if (bom3 && head_nxt[7:0] == tes_pkg::BOM_FF
                 && head_nxt[15:8] == tes_pkg::BOM_FE) begin
      tt_nxt = (bom4 && head_nxt[31:16] == 16'd0) ? tes_pkg::TT_UTF32LE
                                                   : tes_pkg::TT_UTF16LE;
    end else if (bom3 && head_nxt[7:0] == tes_pkg::BOM_FE
                 && head_nxt[15:8] == tes_pkg::BOM_FF) begin
      tt_nxt = tes_pkg::TT_UTF16BE;
    end else if (bom4 && head_nxt[15:0] == 16'd0 && head_nxt[23:16] == tes_pkg::BOM_FE
                 && head_nxt[31:24] == tes_pkg::BOM_FF) begin
      tt_nxt = tes_pkg::TT_UTF32BE;
    end else if (!zero_nxt && cnt_nxt != '0 && prn_scaled >= cnt_scaled) begin
      tt_nxt = tes_pkg::TT_ASCII;
    end else if (!u8_fail_nxt) begin
      tt_nxt = tes_pkg::TT_UTF8;
    end else if (cnt_nxt >= CW'(2) && !cnt_nxt[0] && !bad16[0]) begin
      tt_nxt = tes_pkg::TT_UTF16LE;
    end else if (cnt_nxt >= CW'(2) && !cnt_nxt[0] && !bad16[1]) begin
      tt_nxt = tes_pkg::TT_UTF16BE;
    end else begin
      tt_nxt = tes_pkg::TT_PLAIN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_v_r <= in_chan.valid;
    end
    if (in_chan.ready && in_chan.valid) begin
      in_byte_r <= in_chan.data_byte;
      in_last_r <= in_chan.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pct_r <= tes_pkg::PCT_RESET;
    end else if (cfg_we) begin
      pct_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (process && in_last_r)) begin
      head_r    <= '0;
      cnt_r     <= '0;
      prn_r     <= '0;
      zero_r    <= 1'b0;
      u8_pend_r <= 2'd0;
      u8_bad_r  <= 1'b0;
      u8_fail_r <= 1'b0;
      prev_r    <= 8'd0;
      le_r      <= '0;
      be_r      <= '0;
    end else if (process) begin
      head_r    <= head_nxt;
      cnt_r     <= cnt_nxt;
      prn_r     <= prn_nxt;
      zero_r    <= zero_nxt;
      u8_pend_r <= u8_pend_nxt;
      u8_bad_r  <= u8_bad_nxt;
      u8_fail_r <= u8_fail_nxt;
      prev_r    <= prev_nxt;
      le_r      <= le_nxt;
      be_r      <= be_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (process && in_last_r) begin
      out_v_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_v_r <= 1'b0;
    end
    if (process && in_last_r) begin
      tt_r  <= tt_nxt;
      len_r <= cnt_nxt;
    end
  end

  assign len_ext = {{tes_pkg::SAMPLE_LEN_W{1'b0}}, len_r};
  assign out_chan.valid         = out_v_r;
  assign out_chan.enc_kind      = tt_r;
  assign out_chan.sample_length = len_ext[tes_pkg::SAMPLE_LEN_W-1:0];

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_SAMPLE)) else $error("byte count past sample limit");

  a_prn_bound: assert property (@(posedge clk) disable iff (!rst_n)
    prn_r <= cnt_r) else $error("printable count exceeds byte count");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    process && in_last_r |=> cnt_r == '0 && out_v_r)
    else $error("last byte did not close the sample");

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;
  import tes_pkg::*;

  localparam int SAMPLE_CAP = MAX_SAMPLE_DEF;
  localparam int RANDOM_BYTES = 1950;
  localparam int HOLD_CYCLES = 80;
  localparam int STALL_LIMIT = 2000;

  typedef logic [7:0] byte_q_t[$];

  typedef struct {
    enc_kind_t                 kind;
    logic [SAMPLE_LEN_W-1:0]   len;
  } verdict_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [PCT_W-1:0] cfg_data;

  tes_in_if  in_chan ();
  tes_out_if out_chan ();

  text_encoding_sniffer_unit #(
    .MAX_SAMPLE(SAMPLE_CAP)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always #6 clk = ~clk;

  // sniffer state as seen by the testbench
  logic [PCT_W-1:0] pct;
  logic [31:0]      hd_bytes;
  int               n_seen;
  int               n_print;
  bit               saw_zero;
  int               u8_left;
  bit               u8_bad_open;
  bit               u8_bad;
  logic [7:0]       prev_b;
  logic [1:0]       u16_wait_lo;
  logic [1:0]       u16_bad;

  verdict_t verdict_q[$];
  byte_q_t  sample_buf;
  int       fails;
  int       bytes_sent;
  int       tx_idle_pct;
  int       rx_stall_pct;
  int       hold_req_cnt;
  int       hold_seen_cnt;
  int       stall_cycles;

  function automatic void clear_sample();
    hd_bytes = '0;
    n_seen = 0;
    n_print = 0;
    saw_zero = 1'b0;
    u8_left = 0;
    u8_bad_open = 1'b0;
    u8_bad = 1'b0;
    prev_b = '0;
    u16_wait_lo = '0;
    u16_bad = '0;
  endfunction

  // lane 0 is little endian, lane 1 big endian
  function automatic void u16_feed(logic [15:0] unit, int lane);
    bit hi;
    bit lo;
    hi = unit inside {[16'hD800:16'hDBFF]};
    lo = unit inside {[16'hDC00:16'hDFFF]};
    if (u16_wait_lo[lane]) begin
      if (!lo) u16_bad[lane] = 1'b1;
      u16_wait_lo[lane] = 1'b0;
    end else if (hi) begin
      u16_wait_lo[lane] = 1'b1;
    end else if (lo) begin
      u16_bad[lane] = 1'b1;
    end
  endfunction

  function automatic enc_kind_t classify_sample();
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic [1:0] bad;
    b0 = hd_bytes[7:0];
    b1 = hd_bytes[15:8];
    b2 = hd_bytes[23:16];
    b3 = hd_bytes[31:24];
    if (n_seen >= 3) begin
      if (b0 == BOM_EF && b1 == BOM_BB && b2 == BOM_BF) return TT_UTF8_BOM;
      if (b0 == BOM_FF && b1 == BOM_FE) begin
        if (n_seen >= 4 && b2 == 8'h00 && b3 == 8'h00) return TT_UTF32LE;
        return TT_UTF16LE;
      end
      if (b0 == BOM_FE && b1 == BOM_FF) return TT_UTF16BE;
      if (n_seen >= 4 && b0 == 8'h00 && b1 == 8'h00 && b2 == BOM_FE && b3 == BOM_FF)
        return TT_UTF32BE;
    end
    if (!saw_zero && n_seen > 0 && n_print * 100 >= int'(pct) * n_seen) return TT_ASCII;
    if (!u8_bad) return TT_UTF8;
    if (n_seen >= 2 && n_seen % 2 == 0) begin
      bad = u16_bad | u16_wait_lo;
      if (!bad[0]) return TT_UTF16LE;
      if (!bad[1]) return TT_UTF16BE;
    end
    return TT_PLAIN;
  endfunction

  function automatic void sniff_byte(logic [7:0] b, bit is_last);
    verdict_t v;
    if (n_seen < SAMPLE_CAP) begin
      if (n_seen < 4) hd_bytes[8*n_seen +: 8] = b;
      if ((b >= 8'd32 && b <= 8'd126) || b == 8'd9 || b == 8'd10 || b == 8'd13)
        n_print++;
      else if (b == 8'h00)
        saw_zero = 1'b1;
      if (u8_left > 0) begin
        if (b[7:6] != 2'b10) u8_bad_open = 1'b1;
        u8_left--;
        if (u8_left == 0) begin
          if (u8_bad_open) u8_bad = 1'b1;
          u8_bad_open = 1'b0;
        end
      end else if (!b[7]) begin
        // plain 7-bit character
      end else if (b[7:5] == 3'b110) begin
        u8_left = 1;
      end else if (b[7:4] == 4'b1110) begin
        u8_left = 2;
      end else if (b[7:3] == 5'b11110) begin
        u8_left = 3;
      end else begin
        u8_bad = 1'b1;
      end
      if (n_seen % 2 == 1) begin
        u16_feed({b, prev_b}, 0);
        u16_feed({prev_b, b}, 1);
      end
      prev_b = b;
      n_seen++;
    end
    if (is_last) begin
      v.kind = classify_sample();
      v.len = n_seen[SAMPLE_LEN_W-1:0];
      verdict_q.push_back(v);
      clear_sample();
    end
  endfunction

  function automatic void check_verdict();
    verdict_t v;
    if (verdict_q.size() == 0) begin
      $error("unexpected result: enc_kind %0d sample_length %0d",
             out_chan.enc_kind, out_chan.sample_length);
      fails++;
      return;
    end
    v = verdict_q.pop_front();
    if (out_chan.enc_kind !== v.kind) begin
      $error("enc_kind mismatch: expected %0d, got %0d", v.kind, out_chan.enc_kind);
      fails++;
    end
    if (out_chan.sample_length !== v.len) begin
      $error("sample_length mismatch: expected %0d, got %0d", v.len, out_chan.sample_length);
      fails++;
    end
  endfunction

  // result side: random stalls plus an occasional long hold-off
  initial begin : rx_side
    int hold_left;
    hold_left = 0;
    hold_seen_cnt = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_chan.valid && out_chan.ready) check_verdict();
      if (hold_req_cnt != hold_seen_cnt) begin
        hold_seen_cnt = hold_req_cnt;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // valid stays high after a request so back-to-back bytes need no extra step;
  // anything that lets time pass otherwise lowers it first
  task automatic push_byte(input logic [7:0] b, input bit is_last);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.data_byte <= b;
    in_chan.last <= is_last;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    bytes_sent++;
    sniff_byte(b, is_last);
  endtask

  task automatic send_bytes(input byte_q_t s);
    foreach (s[i]) push_byte(s[i], i == s.size() - 1);
  endtask

  task automatic drain_results();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_percent(input logic [PCT_W-1:0] p);
    drain_results();
    cfg_we <= 1'b1;
    cfg_data <= p;
    @(posedge clk);
    cfg_we <= 1'b0;
    pct = p;
  endtask

  function automatic void add_bom(int which);
    case (which)
      0: begin sample_buf.push_back(BOM_EF); sample_buf.push_back(BOM_BB);
               sample_buf.push_back(BOM_BF); end
      1: begin sample_buf.push_back(BOM_FF); sample_buf.push_back(BOM_FE); end
      2: begin sample_buf.push_back(BOM_FE); sample_buf.push_back(BOM_FF); end
      3: begin sample_buf.push_back(BOM_FF); sample_buf.push_back(BOM_FE);
               sample_buf.push_back(8'h00); sample_buf.push_back(8'h00); end
      default: begin sample_buf.push_back(8'h00); sample_buf.push_back(8'h00);
               sample_buf.push_back(BOM_FE); sample_buf.push_back(BOM_FF); end
    endcase
  endfunction

  function automatic void add_utf8_char(bit corrupt);
    int k;
    logic [7:0] lead;
    k = $urandom_range(1, 4);
    case (k)
      1: lead = 8'($urandom_range(0, 127));
      2: lead = {3'b110, 5'($urandom)};
      3: lead = {4'b1110, 4'($urandom)};
      default: lead = {5'b11110, 3'($urandom)};
    endcase
    sample_buf.push_back(lead);
    for (int i = 1; i < k; i++)
      sample_buf.push_back((corrupt && $urandom_range(3) == 0) ? 8'($urandom)
                                                                : {2'b10, 6'($urandom)});
  endfunction

  function automatic void add_utf16_unit(logic [15:0] u, bit be);
    if (be) begin
      sample_buf.push_back(u[15:8]);
      sample_buf.push_back(u[7:0]);
    end else begin
      sample_buf.push_back(u[7:0]);
      sample_buf.push_back(u[15:8]);
    end
  endfunction

  function automatic void add_utf16_char(bit be);
    int m;
    m = $urandom_range(9);
    if (m <= 5) begin
      if ($urandom_range(1)) add_utf16_unit(16'($urandom_range(0, 127)), be);
      else add_utf16_unit(16'($urandom_range(16'hE000, 16'hFFFF)), be);
    end else if (m <= 7) begin
      add_utf16_unit(16'($urandom_range(16'hD800, 16'hDBFF)), be);
      add_utf16_unit(16'($urandom_range(16'hDC00, 16'hDFFF)), be);
    end else if (m == 8) begin
      add_utf16_unit(16'($urandom_range(16'hD800, 16'hDBFF)), be);
    end else begin
      add_utf16_unit(16'($urandom_range(16'hDC00, 16'hDFFF)), be);
    end
  endfunction

  function automatic void build_sample();
    int shape;
    int cnt;
    int r;
    bit be;
    bit corrupt;
    logic [7:0] specials[7];
    specials = '{8'h00, BOM_FF, BOM_FE, BOM_EF, BOM_BB, BOM_BF, 8'h80};
    sample_buf.delete();
    shape = $urandom_range(9);
    case (shape)
      0: begin
        cnt = $urandom_range(1, 16);
        repeat (cnt) sample_buf.push_back(8'($urandom));
      end
      1, 2: begin
        cnt = ($urandom_range(15) == 0) ? $urandom_range(40, 250) : $urandom_range(1, 30);
        repeat (cnt) begin
          r = $urandom_range(19);
          if (r == 0) sample_buf.push_back(8'($urandom_range(0, 31)));
          else if (r == 1) sample_buf.push_back(8'($urandom_range(128, 255)));
          else if (r == 2) sample_buf.push_back(8'd10);
          else sample_buf.push_back(8'($urandom_range(32, 126)));
        end
      end
      3, 4: begin
        corrupt = ($urandom_range(4) == 0);
        cnt = $urandom_range(1, 8);
        repeat (cnt) add_utf8_char(corrupt);
        // cut the last sequence short now and then
        if ($urandom_range(4) == 0 && sample_buf.size() > 1) void'(sample_buf.pop_back());
      end
      5, 6: begin
        be = $urandom_range(1);
        if ($urandom_range(3) == 0) add_bom(be ? 2 : 1);
        cnt = $urandom_range(1, 8);
        repeat (cnt) add_utf16_char(be);
        if ($urandom_range(7) == 0) void'(sample_buf.pop_back());
      end
      7: begin
        add_bom($urandom_range(4));
        cnt = $urandom_range(0, 6);
        repeat (cnt) sample_buf.push_back(8'($urandom));
      end
      default: begin
        cnt = $urandom_range(1, 5);
        repeat (cnt) begin
          if ($urandom_range(5) == 0) sample_buf.push_back(8'($urandom));
          else sample_buf.push_back(specials[$urandom_range(6)]);
        end
      end
    endcase
  endfunction

  task automatic test_byte_order_marks();
    send_bytes('{BOM_EF, BOM_BB, BOM_BF});
    send_bytes('{BOM_FF, BOM_FE, 8'h00, 8'h00});
    send_bytes('{BOM_FF, BOM_FE, 8'h00});
    send_bytes('{BOM_FE, BOM_FF, 8'h41});
    send_bytes('{8'h00, 8'h00, BOM_FE, BOM_FF});
    // too short for a mark
    send_bytes('{BOM_FF, BOM_FE});
  endtask

  task automatic test_ascii_threshold();
    send_bytes('{8'h48, 8'h09, 8'h0D, 8'h0A, 8'h7E, 8'h20});
    send_bytes('{8'h41, 8'h00, 8'h42});
    send_bytes('{8'h7F});
    // exactly at 90 percent, then just under
    send_bytes('{8'h41, 8'h41, 8'h41, 8'h41, 8'h41, 8'h41, 8'h41, 8'h41, 8'h41, 8'h80});
    send_bytes('{8'h41, 8'h41, 8'h41, 8'h41, 8'h41, 8'h41, 8'h41, 8'h41, 8'hFF});
    set_percent(7'd0);
    send_bytes('{8'h01, 8'hFF, 8'h80});
    set_percent(7'd127);
    send_bytes('{8'h41, 8'h42, 8'h43});
    set_percent(PCT_RESET);
  endtask

  task automatic test_utf8_sequences();
    send_bytes('{8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'hF0, 8'h9F, 8'h98, 8'h80});
    send_bytes('{8'hC3, 8'h41});
    // mismatch inside an unfinished tail is dropped
    send_bytes('{8'h41, 8'h42, 8'hE2, 8'h41});
    send_bytes('{8'hF8, 8'h80});
  endtask

  task automatic test_utf16_pairs();
    send_bytes('{8'h3D, 8'hD8, 8'h00, 8'hDE, 8'h41, 8'h00});
    send_bytes('{8'hD8, 8'h3D, 8'hDE, 8'h00, 8'h00, 8'h41});
    // high surrogate left dangling in the last unit
    send_bytes('{8'h41, 8'h00, 8'h3D, 8'hD8});
    send_bytes('{8'h41, 8'h00, 8'hC3});
  endtask

  task automatic test_backpressure();
    drain_results();
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    hold_req_cnt++;
    for (int i = 0; i < 12; i++) send_bytes('{8'(8'h30 + i), 8'hC3, 8'hA9});
    drain_results();
  endtask

  task automatic test_overlong_sample();
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    sample_buf.delete();
    // zero bytes past the cap must not count
    for (int i = 0; i < SAMPLE_CAP + 6; i++)
      sample_buf.push_back(i < SAMPLE_CAP ? 8'(8'h61 + i % 26) : 8'h00);
    send_bytes(sample_buf);
  endtask

  task automatic test_random_traffic();
    int pcts[8];
    int target;
    pcts = '{90, 0, 100, 127, 50, 1, 99, 75};
    for (int ph = 0; ph < 8; ph++) begin
      set_percent(ph == 7 ? 7'($urandom_range(0, 127)) : 7'(pcts[ph]));
      case (ph % 4)
        0: begin tx_idle_pct = 0; rx_stall_pct = 0; end
        1: begin tx_idle_pct = 83; rx_stall_pct = 0; end
        2: begin tx_idle_pct = 0; rx_stall_pct = 83; end
        default: begin tx_idle_pct = 10; rx_stall_pct = 10; end
      endcase
      target = bytes_sent + RANDOM_BYTES / 8;
      while (bytes_sent < target) begin
        build_sample();
        send_bytes(sample_buf);
      end
    end
  endtask

  initial begin
    in_chan.valid <= 1'b0;
    in_chan.data_byte <= '0;
    in_chan.last <= 1'b0;
    cfg_we <= 1'b0;
    cfg_data <= '0;
    rst_n <= 1'b0;
    fails = 0;
    bytes_sent = 0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    hold_req_cnt = 0;
    stall_cycles = 0;
    pct = PCT_RESET;
    clear_sample();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_byte_order_marks();
    test_ascii_threshold();
    test_utf8_sequences();
    test_utf16_pairs();
    test_backpressure();
    test_overlong_sample();
    test_random_traffic();
    test_backpressure();

    drain_results();
    if (fails == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

[filelist.f]
rtl/tes_pkg.sv
rtl/tes_in_if.sv
rtl/tes_out_if.sv
rtl/text_encoding_sniffer_unit.sv
verif/tb.sv
